// ===== sv/camera_ray_direction_top_macros.svh =====
// assertion macros for the camera ray direction block
// used by camera_ray_direction_top; expects clk and rst_n in scope
`ifndef CAMERA_RAY_DIRECTION_TOP_MACROS_SVH
`define CAMERA_RAY_DIRECTION_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define CRD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("crd check failed");
`define CRD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("crd check failed");
`else
`define CRD_ASSERT_IMP(lbl, ante, cons)
`define CRD_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== sv/crd_pkg.sv =====
// shared constants, types and the reciprocal square root seed table
// for the camera ray direction block; no dependencies
package crd_pkg;

  localparam int CRD_COMPONENT_BITS   = 16;
  localparam int CRD_RSQRT_ITERATIONS = 2;
  localparam int CRD_CFG_IDX_W        = 3;

  // register indexes
  localparam logic [CRD_CFG_IDX_W-1:0] CFG_FORWARD = 3'd0;
  localparam logic [CRD_CFG_IDX_W-1:0] CFG_RIGHT   = 3'd1;
  localparam logic [CRD_CFG_IDX_W-1:0] CFG_UP      = 3'd2;
  localparam logic [CRD_CFG_IDX_W-1:0] CFG_ASPECT  = 3'd3;
  localparam logic [CRD_CFG_IDX_W-1:0] CFG_TAN     = 3'd4;

  localparam logic [15:0] ASPECT_RST = 16'd4096;
  localparam logic [14:0] TAN_RST    = 15'd6786;

  // fixed widths of the normalised datapath
  localparam int E_W  = 30;
  localparam int S_W  = 62;
  localparam int Y_W  = 32;
  localparam int KH_W = 5;

  typedef struct packed {
    logic vld;
    logic zero;
  } crd_ctl_t;

  // 1/sqrt at interval midpoints, Q.16, indexed by the top four bits of s
  function automatic logic [16:0] rsqrt_seed(input logic [3:0] idx);
    logic [16:0] val;
    case (idx)
      4'd4:    val = 17'd123576;
      4'd5:    val = 17'd111779;
      4'd6:    val = 17'd102821;
      4'd7:    val = 17'd95721;
      4'd8:    val = 17'd89915;
      4'd9:    val = 17'd85051;
      4'd10:   val = 17'd80899;
      4'd11:   val = 17'd77302;
      4'd12:   val = 17'd74146;
      4'd13:   val = 17'd71347;
      4'd14:   val = 17'd68842;
      4'd15:   val = 17'd66585;
      default: val = 17'd0;
    endcase
    return val;
  endfunction

endpackage

// ===== sv/crd_dir.sv =====
// unnormalised direction: screen scaling and basis combination, five stages
// depends on crd_pkg
module crd_dir #(
  parameter int L = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    vld_in,
  input  logic signed [15:0]      sx,
  input  logic signed [15:0]      sy,
  input  logic [3*L-1:0]          fwd,
  input  logic [3*L-1:0]          rgt,
  input  logic [3*L-1:0]          upv,
  input  logic [15:0]             aspect,
  input  logic [14:0]             tanv,
  output logic                    vld_out,
  output logic [2:0][L+20:0]      mag_out,
  output logic [2:0]              neg_out
);
  import crd_pkg::*;

  localparam int DW = L + 22;
  localparam int MW = L + 21;

  logic [4:0]        vld_r;
  logic [30:0]       px_r, py_r;
  logic              xn1_r, yn1_r, xn2_r;
  logic [46:0]       pxa_r;
  logic signed [17:0] v2_r, v3_r;
  logic signed [21:0] h_r;
  logic signed [DW-1:0] fp_r [3];
  logic signed [DW-1:0] rp_r [3];
  logic signed [DW-1:0] up_r [3];
  logic [MW-1:0]     mag_r [3];
  logic [2:0]        neg_r;

  logic [15:0]       ax, ay;
  logic [16:0]       vmag;
  logic [20:0]       hmag;
  logic signed [DW-1:0] d [3];

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[3:0], vld_in};
    end
  end

  assign ax   = sx[15] ? 16'(-sx) : 16'(sx);
  assign ay   = sy[15] ? 16'(-sy) : 16'(sy);
  assign vmag = 17'((py_r + 31'd8192) >> 14);
  assign hmag = 21'((pxa_r + 47'(33554432)) >> 26);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d[i] = fp_r[i] + rp_r[i] + up_r[i];
    end
  end

  // datapath stages
  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1: coordinate magnitudes times tan
      px_r  <= 31'(ax) * 31'(tanv);
      py_r  <= 31'(ay) * 31'(tanv);
      xn1_r <= sx[15];
      yn1_r <= sy[15];
      // stage 2: aspect and vertical rounding
      pxa_r <= 47'(px_r) * 47'(aspect);
      xn2_r <= xn1_r;
      v2_r  <= yn1_r ? -$signed(18'(vmag)) : $signed(18'(vmag));
      // stage 3: horizontal rounding
      h_r   <= xn2_r ? -$signed(22'(hmag)) : $signed(22'(hmag));
      v3_r  <= v2_r;
      // stage 4: lane products
      for (int i = 0; i < 3; i++) begin
        fp_r[i] <= DW'($signed(fwd[i*L +: L])) <<< 14;
        rp_r[i] <= DW'($signed(rgt[i*L +: L])) * DW'(h_r);
        up_r[i] <= DW'($signed(upv[i*L +: L])) * DW'(v3_r);
      end
      // stage 5: sum and magnitude
      for (int i = 0; i < 3; i++) begin
        neg_r[i] <= d[i][DW-1];
        mag_r[i] <= d[i][DW-1] ? MW'(-d[i]) : MW'(d[i]);
      end
    end
  end

  assign vld_out = vld_r[4];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_out[i] = mag_r[i];
    end
  end
  assign neg_out = neg_r;

endmodule

// ===== sv/crd_norm.sv =====
// range reduction: max, pre-shift, squared length and even normalising shift
// depends on crd_pkg
module crd_norm #(
  parameter int MAG_W = 37
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         vld_in,
  input  logic [2:0][MAG_W-1:0]        mag_in,
  input  logic [2:0]                   neg_in,
  output crd_pkg::crd_ctl_t            ctl_out,
  output logic [2:0][crd_pkg::E_W-1:0] e_out,
  output logic [2:0]                   neg_out,
  output logic [crd_pkg::KH_W-1:0]     kh_out,
  output logic [crd_pkg::S_W-1:0]      s_out
);
  import crd_pkg::*;

  localparam int BLW = $clog2(MAG_W + 1);
  localparam int NST = 7;

  logic [NST-1:0]    vld_r;
  logic [NST-1:1]    zero_r;
  logic [2:0]        neg_r [NST];
  logic [MAG_W-1:0]  mag1_r [3];
  logic [MAG_W-1:0]  mag2_r [3];
  logic [MAG_W-1:0]  m_r;
  logic [BLW-1:0]    r_r;
  logic [E_W-1:0]    e_r [5][3];
  logic [2*E_W-1:0]  sq_r [3];
  logic [S_W-1:0]    s_r, s6_r, sn_r;
  logic [KH_W-1:0]   kh6_r, kh7_r;

  logic [MAG_W-1:0]  m_nxt;
  logic [BLW-1:0]    bl;
  logic [5:0]        sbl;
  logic [5:0]        kdiff;

  // control bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], vld_in};
    end
  end

  // maximum magnitude
  always_comb begin
    m_nxt = mag_in[0];
    if (mag_in[1] > m_nxt) m_nxt = mag_in[1];
    if (mag_in[2] > m_nxt) m_nxt = mag_in[2];
  end

  // bit length of the maximum
  always_comb begin
    bl = '0;
    for (int b = 0; b < MAG_W; b++) begin
      if (m_r[b]) bl = BLW'(b + 1);
    end
  end

  // bit length of the squared sum
  always_comb begin
    sbl = '0;
    for (int b = 0; b < S_W; b++) begin
      if (s_r[b]) sbl = 6'(b + 1);
    end
    kdiff = 6'(S_W) - sbl;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg_r[0] <= neg_in;
      for (int j = 1; j < NST; j++) begin
        neg_r[j] <= neg_r[j-1];
      end
      zero_r[NST-1:2] <= zero_r[NST-2:1];
      // stage 1: max
      m_r <= m_nxt;
      for (int i = 0; i < 3; i++) mag1_r[i] <= mag_in[i];
      // stage 2: pre-shift count and zero flag
      r_r       <= (bl > BLW'(E_W)) ? BLW'(bl - BLW'(E_W)) : '0;
      zero_r[1] <= (m_r == '0);
      for (int i = 0; i < 3; i++) mag2_r[i] <= mag1_r[i];
      // stage 3: reduce to 30 bits
      for (int i = 0; i < 3; i++) e_r[0][i] <= E_W'(mag2_r[i] >> r_r);
      // stage 4: squares
      for (int i = 0; i < 3; i++) sq_r[i] <= 60'(e_r[0][i]) * 60'(e_r[0][i]);
      // stage 5: sum
      s_r <= S_W'(sq_r[0]) + S_W'(sq_r[1]) + S_W'(sq_r[2]);
      // stage 6: even shift count
      kh6_r <= kdiff[5:1];
      s6_r  <= s_r;
      // stage 7: normalise
      kh7_r <= kh6_r;
      sn_r  <= s6_r << {kh6_r, 1'b0};
      for (int j = 1; j < 5; j++) begin
        for (int i = 0; i < 3; i++) e_r[j][i] <= e_r[j-1][i];
      end
    end
  end

  assign ctl_out.vld  = vld_r[NST-1];
  assign ctl_out.zero = zero_r[NST-1];
  always_comb begin
    for (int i = 0; i < 3; i++) e_out[i] = e_r[4][i];
  end
  assign neg_out = neg_r[NST-1];
  assign kh_out  = kh7_r;
  assign s_out   = sn_r;

endmodule

// ===== sv/crd_rsqrt.sv =====
// reciprocal square root: seed table then pipelined newton steps
// depends on crd_pkg
module crd_rsqrt #(
  parameter int ITER = 2,
  parameter int SIDE_W = 98
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  crd_pkg::crd_ctl_t         ctl_in,
  input  logic [crd_pkg::S_W-1:0]   s_in,
  input  logic [SIDE_W-1:0]         side_in,
  output crd_pkg::crd_ctl_t         ctl_out,
  output logic [crd_pkg::Y_W-1:0]   y_out,
  output logic [SIDE_W-1:0]         side_out
);
  import crd_pkg::*;

  localparam int NS = 1 + 3 * ITER;
  localparam logic [33:0] W_LIM = 34'h0_C000_0000;

  crd_ctl_t          ctl_r  [NS];
  logic [SIDE_W-1:0] side_r [NS];
  logic [Y_W-1:0]    y_s [ITER+1];
  logic [29:0]       x_s [ITER+1];
  logic [Y_W-1:0]    y0_r;
  logic [29:0]       x0_r;

  // control travels with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < NS; j++) ctl_r[j] <= '0;
    end else if (en) begin
      ctl_r[0] <= ctl_in;
      for (int j = 1; j < NS; j++) ctl_r[j] <= ctl_r[j-1];
    end
  end

  // seed stage and side data
  always_ff @(posedge clk) begin
    if (en) begin
      y0_r      <= Y_W'(rsqrt_seed(s_in[61:58])) << 14;
      x0_r      <= s_in[61:32];
      side_r[0] <= side_in;
      for (int j = 1; j < NS; j++) side_r[j] <= side_r[j-1];
    end
  end

  assign y_s[0] = y0_r;
  assign x_s[0] = x0_r;

  // one newton step: square, scale by x, multiply by correction
  for (genvar it = 0; it < ITER; it++) begin : g_step
    logic [33:0]    y2_r, t_r;
    logic [Y_W-1:0] ya_r, yb_r, yn_r;
    logic [29:0]    xa_r, xb_r, xc_r;
    logic [63:0]    psq, pxt, pyw;
    logic [31:0]    w;

    assign psq = 64'(y_s[it]) * 64'(y_s[it]);
    assign pxt = 64'(xa_r) * 64'(y2_r);
    assign w   = (t_r < W_LIM) ? 32'(W_LIM - t_r) : 32'd0;
    assign pyw = 64'(yb_r) * 64'(w);

    always_ff @(posedge clk) begin
      if (en) begin
        y2_r <= psq[63:30];
        ya_r <= y_s[it];
        xa_r <= x_s[it];
        t_r  <= pxt[63:30];
        yb_r <= ya_r;
        xb_r <= xa_r;
        yn_r <= pyw[62:31];
        xc_r <= xb_r;
      end
    end

    assign y_s[it+1] = yn_r;
    assign x_s[it+1] = xc_r;
  end

  assign ctl_out  = ctl_r[NS-1];
  assign y_out    = y_s[ITER];
  assign side_out = side_r[NS-1];

endmodule

// ===== sv/crd_scale.sv =====
// final scaling of each component by the reciprocal length, rounding, saturation
// depends on crd_pkg; its last stage is the output register
module crd_scale #(
  parameter int L = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  crd_pkg::crd_ctl_t            ctl_in,
  input  logic [crd_pkg::Y_W-1:0]      y_in,
  input  logic [2:0][crd_pkg::E_W-1:0] e_in,
  input  logic [2:0]                   neg_in,
  input  logic [crd_pkg::KH_W-1:0]     kh_in,
  output crd_pkg::crd_ctl_t            ctl_out,
  output logic [2:0][L-1:0]            dir_out
);
  import crd_pkg::*;

  localparam int F  = L - 2;
  localparam int PW = E_W + Y_W;
  localparam logic [PW:0] ONE = (PW+1)'(1) << F;

  crd_ctl_t        ctl_r [2];
  logic [PW-1:0]   prod_r [3];
  logic [2:0]      neg_r;
  logic [KH_W-1:0] kh_r;
  logic [L-1:0]    dir_r [3];

  logic [5:0]      sh;
  logic [PW:0]     rnd;
  logic [PW:0]     q [3];
  logic [L-1:0]    qs [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r[0] <= '0;
      ctl_r[1] <= '0;
    end else if (en) begin
      ctl_r[0] <= ctl_in;
      ctl_r[1] <= ctl_r[0];
    end
  end

  // rounding shift depends on the normalising shift
  assign sh  = 6'(61 - F) - 6'(kh_r);
  assign rnd = (PW+1)'(1) << (sh - 6'd1);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      q[i]  = ((PW+1)'(prod_r[i]) + rnd) >> sh;
      qs[i] = (q[i] > ONE) ? L'(ONE) : L'(q[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1: products
      for (int i = 0; i < 3; i++) prod_r[i] <= PW'(e_in[i]) * PW'(y_in);
      neg_r <= neg_in;
      kh_r  <= kh_in;
      // stage 2: round, saturate, sign; zero length gives zeros
      for (int i = 0; i < 3; i++) begin
        if (ctl_r[0].zero) begin
          dir_r[i] <= '0;
        end else begin
          dir_r[i] <= neg_r[i] ? L'(-qs[i]) : qs[i];
        end
      end
    end
  end

  assign ctl_out = ctl_r[1];
  always_comb begin
    for (int i = 0; i < 3; i++) dir_out[i] = dir_r[i];
  end

endmodule

// ===== sv/camera_ray_direction_top.sv =====
// camera ray direction generator, top level with configuration registers
// depends on crd_pkg, crd_dir, crd_norm, crd_rsqrt, crd_scale and the macro header
//
//  channel | signals                                      | handshake
//  --------+----------------------------------------------+----------------
//  input   | in_screen_x, in_screen_y                     | in_valid/in_stall
//  result  | out_dir_x/y/z, out_zero_length               | out_valid/out_stall
//  config  | cfg_index, cfg_data                          | cfg_valid/cfg_ready
//
// one item per cycle while no result waits under out_stall; the pipeline is a chain of
// registered multipliers, newton steps three stages each.
// reset is synchronous and clears the valid bits and the registers to the default camera.
// the whole pipeline holds while a result waits under out_stall; in_stall follows that.
// configuration writes are always taken (cfg_ready is high).
`include "camera_ray_direction_top_macros.svh"
module camera_ray_direction_top #(
  parameter int COMPONENT_BITS   = crd_pkg::CRD_COMPONENT_BITS,
  parameter int RSQRT_ITERATIONS = crd_pkg::CRD_RSQRT_ITERATIONS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [15:0]                in_screen_x,
  input  logic signed [15:0]                in_screen_y,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [COMPONENT_BITS-1:0]  out_dir_x,
  output logic signed [COMPONENT_BITS-1:0]  out_dir_y,
  output logic signed [COMPONENT_BITS-1:0]  out_dir_z,
  output logic                              out_zero_length,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [crd_pkg::CRD_CFG_IDX_W-1:0] cfg_index,
  input  logic [3*COMPONENT_BITS-1:0]       cfg_data
);
  import crd_pkg::*;

  localparam int L      = COMPONENT_BITS;
  localparam int F      = L - 2;
  localparam int MAG_W  = L + 21;
  localparam int SIDE_W = 3 + 3 * E_W + KH_W;

  localparam logic [L-1:0] LANE_ZERO = '0;
  localparam logic [L-1:0] LANE_ONE  = {2'b01, {F{1'b0}}};
  localparam logic [L-1:0] LANE_NEG  = {2'b11, {F{1'b0}}};
  localparam logic signed [L-1:0] DIR_ONE = LANE_ONE;
  localparam logic signed [L-1:0] DIR_NEG = LANE_NEG;

  logic [3*L-1:0] fwd_r, rgt_r, up_r;
  logic [15:0]    aspect_r;
  logic [14:0]    tan_r;

  logic                   adv;
  logic                   d_vld;
  logic [2:0][MAG_W-1:0]  d_mag;
  logic [2:0]             d_neg;
  crd_ctl_t               n_ctl, r_ctl, o_ctl;
  logic [2:0][E_W-1:0]    n_e;
  logic [2:0]             n_neg;
  logic [KH_W-1:0]        n_kh;
  logic [S_W-1:0]         n_s;
  logic [SIDE_W-1:0]      r_side;
  logic [Y_W-1:0]         r_y;
  logic [2:0][L-1:0]      o_dir;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r    <= {LANE_NEG, LANE_ZERO, LANE_ZERO};
      rgt_r    <= {LANE_ZERO, LANE_ZERO, LANE_ONE};
      up_r     <= {LANE_ZERO, LANE_ONE, LANE_ZERO};
      aspect_r <= ASPECT_RST;
      tan_r    <= TAN_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FORWARD: fwd_r    <= cfg_data;
        CFG_RIGHT:   rgt_r    <= cfg_data;
        CFG_UP:      up_r     <= cfg_data;
        CFG_ASPECT:  aspect_r <= cfg_data[15:0];
        CFG_TAN:     tan_r    <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  // pipeline advances unless a result is held by the receiver
  assign adv      = !o_ctl.vld || !out_stall;
  assign in_stall = !adv;

  crd_dir #(.L(L)) u_dir (
    .clk(clk), .rst_n(rst_n), .en(adv), .vld_in(in_valid),
    .sx(in_screen_x), .sy(in_screen_y),
    .fwd(fwd_r), .rgt(rgt_r), .upv(up_r), .aspect(aspect_r), .tanv(tan_r),
    .vld_out(d_vld), .mag_out(d_mag), .neg_out(d_neg)
  );

  crd_norm #(.MAG_W(MAG_W)) u_norm (
    .clk(clk), .rst_n(rst_n), .en(adv), .vld_in(d_vld),
    .mag_in(d_mag), .neg_in(d_neg),
    .ctl_out(n_ctl), .e_out(n_e), .neg_out(n_neg), .kh_out(n_kh), .s_out(n_s)
  );

  crd_rsqrt #(.ITER(RSQRT_ITERATIONS), .SIDE_W(SIDE_W)) u_rsqrt (
    .clk(clk), .rst_n(rst_n), .en(adv), .ctl_in(n_ctl), .s_in(n_s),
    .side_in({n_neg, n_e, n_kh}),
    .ctl_out(r_ctl), .y_out(r_y), .side_out(r_side)
  );

  crd_scale #(.L(L)) u_scale (
    .clk(clk), .rst_n(rst_n), .en(adv), .ctl_in(r_ctl), .y_in(r_y),
    .e_in(r_side[SIDE_W-4 -: 3*E_W]), .neg_in(r_side[SIDE_W-1 -: 3]),
    .kh_in(r_side[KH_W-1:0]),
    .ctl_out(o_ctl), .dir_out(o_dir)
  );

  assign out_valid       = o_ctl.vld;
  assign out_zero_length = o_ctl.zero;
  assign out_dir_x       = o_dir[0];
  assign out_dir_y       = o_dir[1];
  assign out_dir_z       = o_dir[2];

  // checks
  `CRD_ASSERT_IMP(a_zero_gives_zeros, out_valid && out_zero_length, (out_dir_x == '0) && (out_dir_y == '0) && (out_dir_z == '0))
  `CRD_ASSERT_IMP(a_dir_in_range, out_valid, (out_dir_x <= DIR_ONE) && (out_dir_x >= DIR_NEG) && (out_dir_y <= DIR_ONE) && (out_dir_y >= DIR_NEG) && (out_dir_z <= DIR_ONE) && (out_dir_z >= DIR_NEG))
  `CRD_ASSERT_IMP(a_unit_not_null, out_valid && !out_zero_length, (out_dir_x != '0) || (out_dir_y != '0) || (out_dir_z != '0))
  `CRD_ASSERT_NXT(a_held_result, out_valid && out_stall, out_valid)

endmodule

// ===== tb/camera_ray_direction_top_tb.sv =====
// self-checking testbench for camera_ray_direction_top: random and directed screen points
// against a bit-true ray predictor held in a small scoreboard class; depends on crd_pkg
module camera_ray_direction_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import crd_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam logic [CRD_CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd7;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
    logic        zero;
  } ray_t;

  // scoreboard: camera registers, ray predictor and the queue of expected rays
  class ray_scoreboard;
    logic [47:0] fwd, rgt, upv;
    logic [15:0] aspect;
    logic [14:0] tanh;
    ray_t        ray_q[$];
    int          errors;
    longint unsigned seed_tab[12] = '{123576, 111779, 102821, 95721, 89915, 85051,
                                      80899, 77302, 74146, 71347, 68842, 66585};

    function new();
      fwd = 48'hC000_0000_0000;
      rgt = 48'd16384;
      upv = 48'd1073741824;
      aspect = ASPECT_RST;
      tanh = TAN_RST;
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [47:0] data);
      case (idx)
        CFG_FORWARD: fwd = data;
        CFG_RIGHT:   rgt = data;
        CFG_UP:      upv = data;
        CFG_ASPECT:  aspect = data[15:0];
        CFG_TAN:     tanh = data[14:0];
        default: ;
      endcase
    endfunction

    // half-away-from-zero rounding divide by a power of two
    function longint round_div(longint p, int sh);
      longint unsigned mg;
      mg = (p < 0) ? -p : p;
      mg = (mg + (64'd1 << (sh - 1))) >> sh;
      return (p < 0) ? -longint'(mg) : longint'(mg);
    endfunction

    function longint lane_of(logic [47:0] vec, int i);
      return longint'($signed(vec[i*16 +: 16]));
    endfunction

    function void note_input(logic signed [15:0] sx, logic signed [15:0] sy);
      longint          hh, vv, d;
      longint unsigned mag[3], m, s, yv, x30, y2, t, w, q;
      bit              neg[3];
      int              r, k, sh;
      ray_t            res;
      hh = round_div(longint'(sx) * longint'({48'd0, aspect}) * longint'({49'd0, tanh}), 26);
      vv = round_div(longint'(sy) * longint'({49'd0, tanh}), 14);
      m = 0;
      for (int i = 0; i < 3; i++) begin
        d = lane_of(fwd, i) * 16384 + lane_of(rgt, i) * hh + lane_of(upv, i) * vv;
        neg[i] = d < 0;
        mag[i] = neg[i] ? -d : d;
        if (mag[i] > m) m = mag[i];
      end
      res = '0;
      if (m == 0) begin
        res.zero = 1'b1;
      end else begin
        r = 0;
        while ((m >> r) >= (64'd1 << 30)) r++;
        s = 0;
        for (int i = 0; i < 3; i++) begin
          mag[i] = mag[i] >> r;
          s += mag[i] * mag[i];
        end
        k = 0;
        while (s < (64'd1 << 60)) begin
          s = s << 2;
          k += 2;
        end
        // table seed then newton refinement of 1/sqrt
        yv = seed_tab[((s >> 58) & 15) - 4] << 14;
        for (int it = 0; it < CRD_RSQRT_ITERATIONS; it++) begin
          x30 = s >> 32;
          y2 = (yv * yv) >> 30;
          t = (x30 * y2) >> 30;
          w = (t < (64'd3 << 30)) ? (64'd3 << 30) - t : 0;
          yv = (yv * w) >> 31;
        end
        sh = 61 - k / 2 - 14;
        for (int i = 0; i < 3; i++) begin
          q = (mag[i] * yv + (64'd1 << (sh - 1))) >> sh;
          if (q > 16384) q = 16384;
          q = neg[i] ? -q : q;
          if (i == 0) res.x = q[15:0];
          else if (i == 1) res.y = q[15:0];
          else res.z = q[15:0];
        end
      end
      ray_q.push_back(res);
    endfunction

    task report(string what, logic [15:0] got, logic [15:0] want);
      $display("mismatch %s: got %0h expected %0h", what, got, want);
      errors++;
    endtask

    task check_result(ray_t got);
      ray_t want;
      if (ray_q.size() == 0) begin
        report("unexpected ray", {got.zero, 15'd0}, 16'd0);
      end else begin
        want = ray_q.pop_front();
        if (got.x !== want.x) report("dir_x", got.x, want.x);
        if (got.y !== want.y) report("dir_y", got.y, want.y);
        if (got.z !== want.z) report("dir_z", got.z, want.z);
        if (got.zero !== want.zero) report("zero_length", {15'd0, got.zero}, {15'd0, want.zero});
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] in_screen_x = '0;
  logic signed [15:0] in_screen_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] out_dir_x, out_dir_y, out_dir_z;
  logic out_zero_length;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [47:0] cfg_data = '0;

  ray_scoreboard sb = new();
  int idle_pct = 18;
  int sent = 0;
  int cycles = 0;

  camera_ray_direction_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_screen_x(in_screen_x), .in_screen_y(in_screen_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_dir_x(out_dir_x), .out_dir_y(out_dir_y), .out_dir_z(out_dir_z),
    .out_zero_length(out_zero_length),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // transfer monitors on all three channels
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_input(in_screen_x, in_screen_y);
    if (rst_n && out_valid && !out_stall)
      sb.check_result({out_dir_x, out_dir_y, out_dir_z, out_zero_length});
    if (rst_n && cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
  end

  // receiver: random stalls plus one long hold-off once traffic is flowing
  initial begin
    int hold_left;
    bit held;
    held = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!held && sent >= 300) begin
        held = 1;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < idle_pct);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout");
      $display("camera_ray_direction_top verification failed");
      $finish;
    end
  end

  task send_point(logic signed [15:0] sx, logic signed [15:0] sy);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_screen_x <= sx;
    in_screen_y <= sy;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  task write_cfg(logic [2:0] idx, logic [47:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task drain();
    in_valid <= 1'b0;
    while (sb.ray_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(3))
      0: return 16'($signed($urandom_range(32768)) - 16384);
      1: return 16'($signed($urandom_range(64)) - 32);
      2: return ($urandom_range(1) ? 16'sd16384 : -16'sd16384);
      default: return 16'($urandom);
    endcase
  endfunction

  // random lanes between -16384 and 16384, or any bit pattern
  function automatic logic [47:0] rand_vec(bit wild);
    logic [47:0] v;
    if (wild) return 48'({$urandom, $urandom});
    v = '0;
    for (int i = 0; i < 3; i++)
      v[i*16 +: 16] = 16'($signed($urandom_range(32768)) - 16384);
    return v;
  endfunction

  initial begin
    logic signed [15:0] pts[10];
    pts = '{16'sd0, 16'sd1, -16'sd1, 16'sd16384, -16'sd16384, 16'sd8192,
            -16'sd8192, 16'sd32767, -16'sd32768, 16'sd12345};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: corners and axes under the reset camera
    for (int i = 0; i < 5; i++)
      for (int j = 0; j < 4; j++) send_point(pts[i], pts[j + 3 * (i % 2)]);
    send_point(pts[7], pts[8]);
    send_point(pts[8], pts[7]);
    drain();

    // zero-length sum: no forward lane, centre of the screen, then one point off centre
    write_cfg(CFG_FORWARD, 48'd0);
    send_point(16'sd0, 16'sd0);
    send_point(16'sd0, 16'sd0);
    send_point(16'sd100, 16'sd0);
    drain();

    // random phases across camera settings, extremes included
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: begin
          write_cfg(CFG_FORWARD, 48'hC000_0000_0000);
          write_cfg(CFG_ASPECT, 48'd1);
          write_cfg(CFG_TAN, 48'd143);
        end
        1: begin
          write_cfg(CFG_ASPECT, 48'd65535);
          write_cfg(CFG_TAN, 48'd28378);
        end
        2: begin
          write_cfg(CFG_ASPECT, 48'd0);
          write_cfg(CFG_TAN, 48'd32767);
        end
        3: begin
          write_cfg(CFG_FORWARD, 48'hFFFF_FFFF_FFFF);
          write_cfg(CFG_RIGHT, 48'h7FFF_7FFF_7FFF);
          write_cfg(CFG_UP, 48'h8000_8000_8000);
        end
        4: begin
          write_cfg(CFG_TAN, 48'd0);
          write_cfg(CFG_FORWARD, 48'd0);
        end
        7: write_cfg(CFG_UNMAPPED, 48'({$urandom, $urandom}));
        default: begin
          write_cfg(CFG_FORWARD, rand_vec(ph > 7));
          write_cfg(CFG_RIGHT, rand_vec(ph > 7));
          write_cfg(CFG_UP, rand_vec(ph > 7));
          write_cfg(CFG_ASPECT, 48'($urandom_range(65535)));
          write_cfg(CFG_TAN, 48'($urandom_range(32767)));
        end
      endcase
      idle_pct = (ph == 5) ? 0 : 18;
      for (int n = 0; n < 160; n++) begin
        if (ph == 4 && n % 4 == 0) send_point(16'sd0, rand_coord());
        else send_point(rand_coord(), rand_coord());
      end
      drain();
    end

    if (sb.errors == 0) begin
      $display("camera_ray_direction_top verification clean");
    end else begin
      $display("camera_ray_direction_top verification failed");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+sv
sv/crd_pkg.sv
sv/crd_dir.sv
sv/crd_norm.sv
sv/crd_rsqrt.sv
sv/crd_scale.sv
sv/camera_ray_direction_top.sv
tb/camera_ray_direction_top_tb.sv
